FILE: src/crc16_checked_frame_receiver_unit_defines.svh
// Assertion macros shared by the frame receiver RTL files.
// Each macro expands to nothing when SYNTHESIS is defined.
`ifndef CRC16_CHECKED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRC16_CHECKED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Concurrent property: prop must hold at every clock edge outside reset.
`define CRCFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("crcfr assertion failed");
// Implication property: cons must hold in the cycle after ante.
`define CRCFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crcfr assertion failed");
`else
`define CRCFR_ASSERT(lbl, prop)
`define CRCFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/crcfr_pkg.sv
// Shared types, constants and CRC-16/MODBUS helpers for the frame receiver.
// No dependencies; the parser, queue, emitter and top level refer to this package.
`timescale 1ns / 1ps

package crcfr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int MAX_LEN     = MAX_PAYLOAD + 2;
  localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int RAM_DEPTH   = 2 << IDX_W;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [4:0]        bidx_t;
  typedef logic [5:0]        maxlen_t;
  typedef logic [1:0]        status_t;
  typedef logic [1:0]        tidx_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_CRC  = 2'd1;
  localparam status_t ST_TAIL = 2'd2;
  localparam status_t ST_LEN  = 2'd3;

  localparam maxlen_t MAX_BODY_RST = 6'd34;
  localparam logic [7:0]  HEADER_BYTE = 8'hEE;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam tidx_t       TAIL_LAST   = 2'd3;

  // Descriptor of one finished frame, handed from the parser to the emitter.
  typedef struct packed {
    logic [15:0] cmd;
    cnt_t        n;
    status_t     status;
    logic        bank;
  } desc_t;

  // Release of a payload bank once its last byte has been read out.
  typedef struct packed {
    logic valid;
    logic bank;
  } clr_t;

  function automatic logic [7:0] tail_byte(input tidx_t i);
    logic [7:0] v;
    case (i)
      2'd0:    v = 8'hFF;
      2'd1:    v = 8'hFD;
      2'd2:    v = 8'hFE;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

  // Table entry of the byte-wise reflected CRC; synthesizes to a constant table.
  function automatic logic [15:0] crc_tab(input logic [7:0] i);
    logic [15:0] c;
    c = {8'h00, i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    return {8'h00, crc[15:8]} ^ crc_tab(crc[7:0] ^ b);
  endfunction

endpackage

FILE: src/crcfr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/crcfr_queue.sv
// Two-entry descriptor queue between the frame parser and the item emitter.
// Depends on crcfr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "crc16_checked_frame_receiver_unit_defines.svh"

module crcfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  crcfr_pkg::desc_t push_desc,
  input  logic             pop,
  output crcfr_pkg::desc_t head,
  output logic             empty,
  output logic             full
);

  crcfr_pkg::desc_t q_r [crcfr_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head  = q_r[rd_ptr_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'(crcfr_pkg::QUEUE_DEPTH));

  // Parser waits while full, emitter while empty: no overrun or underrun.
  `CRCFR_ASSERT(a_no_overrun, !(full && push))
  `CRCFR_ASSERT(a_no_underrun, !(empty && pop))

endmodule

FILE: src/crcfr_front.sv
// Frame parser: hunts for the header, checks length, CRC and tail, stores the payload
// into one of two RAM banks and queues one descriptor per frame. Uses crcfr_pkg.
`timescale 1ns / 1ps
`include "crc16_checked_frame_receiver_unit_defines.svh"

module crcfr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  crcfr_pkg::maxlen_t   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic                 q_full,
  output logic                 push,
  output crcfr_pkg::desc_t     push_desc,
  output logic                 ram_wr_en,
  output crcfr_pkg::addr_t     ram_wr_addr,
  output logic [7:0]           ram_wr_data,
  input  crcfr_pkg::clr_t      clr
);

  typedef enum logic [8:0] {
    S_HUNT   = 9'b000000001,
    S_LEN_HI = 9'b000000010,
    S_LEN_LO = 9'b000000100,
    S_CMD_HI = 9'b000001000,
    S_CMD_LO = 9'b000010000,
    S_PAY    = 9'b000100000,
    S_CRC_HI = 9'b001000000,
    S_CRC_LO = 9'b010000000,
    S_TAIL   = 9'b100000000
  } fstate_t;

  fstate_t             state_r, state_nxt;
  crcfr_pkg::maxlen_t  max_len_r, max_len_nxt;
  logic [7:0]          len_hi_r, len_hi_nxt;
  crcfr_pkg::cnt_t     pay_n_r, pay_n_nxt;
  crcfr_pkg::cnt_t     pay_cnt_r, pay_cnt_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [15:0]         rx_crc_r, rx_crc_nxt;
  logic [15:0]         cmd_r, cmd_nxt;
  crcfr_pkg::tidx_t    tail_idx_r, tail_idx_nxt;
  logic                bank_r, bank_nxt;
  logic [1:0]          busy_r, busy_nxt;
  logic [1:0]          set_mask, clr_mask;
  logic                acc;
  logic [15:0]         len;
  logic                len_bad;

  assign in_stall = q_full || ((state_r == S_PAY) && busy_r[bank_r]);
  assign acc      = in_valid && !in_stall;
  assign len      = {len_hi_r, in_rx_byte};
  assign len_bad  = (len < 16'd2) || (len > {10'd0, max_len_r}) ||
                    (len > 16'(crcfr_pkg::MAX_LEN));

  always_comb begin
    state_nxt    = state_r;
    max_len_nxt  = cfg_wr_en ? cfg_wr_data : max_len_r;
    len_hi_nxt   = len_hi_r;
    pay_n_nxt    = pay_n_r;
    pay_cnt_nxt  = pay_cnt_r;
    crc_nxt      = crc_r;
    rx_crc_nxt   = rx_crc_r;
    cmd_nxt      = cmd_r;
    tail_idx_nxt = tail_idx_r;
    bank_nxt     = bank_r;
    set_mask     = 2'b00;
    push         = 1'b0;
    push_desc    = '{cmd: cmd_r, n: '0, status: crcfr_pkg::ST_OK, bank: bank_r};
    ram_wr_en    = 1'b0;
    ram_wr_addr  = {bank_r, crcfr_pkg::idx_t'(pay_cnt_r)};
    ram_wr_data  = in_rx_byte;

    if (acc) begin
      case (state_r)
        S_HUNT: begin
          if (in_rx_byte == crcfr_pkg::HEADER_BYTE) begin
            state_nxt = S_LEN_HI;
          end
        end
        S_LEN_HI: begin
          len_hi_nxt = in_rx_byte;
          state_nxt  = S_LEN_LO;
        end
        S_LEN_LO: begin
          if (len_bad) begin
            push             = 1'b1;
            push_desc.cmd    = 16'h0000;
            push_desc.status = crcfr_pkg::ST_LEN;
            state_nxt        = S_HUNT;
          end else begin
            pay_n_nxt   = crcfr_pkg::cnt_t'(len - 16'd2);
            pay_cnt_nxt = '0;
            crc_nxt     = crcfr_pkg::CRC_INIT;
            state_nxt   = S_CMD_HI;
          end
        end
        S_CMD_HI: begin
          cmd_nxt   = {in_rx_byte, 8'h00};
          crc_nxt   = crcfr_pkg::crc_next(crc_r, in_rx_byte);
          state_nxt = S_CMD_LO;
        end
        S_CMD_LO: begin
          cmd_nxt   = {cmd_r[15:8], in_rx_byte};
          crc_nxt   = crcfr_pkg::crc_next(crc_r, in_rx_byte);
          state_nxt = (pay_n_r != '0) ? S_PAY : S_CRC_HI;
        end
        S_PAY: begin
          ram_wr_en   = 1'b1;
          crc_nxt     = crcfr_pkg::crc_next(crc_r, in_rx_byte);
          pay_cnt_nxt = pay_cnt_r + 1'b1;
          if (pay_cnt_nxt == pay_n_r) begin
            state_nxt = S_CRC_HI;
          end
        end
        S_CRC_HI: begin
          rx_crc_nxt = {in_rx_byte, 8'h00};
          state_nxt  = S_CRC_LO;
        end
        S_CRC_LO: begin
          rx_crc_nxt   = {rx_crc_r[15:8], in_rx_byte};
          tail_idx_nxt = '0;
          state_nxt    = S_TAIL;
        end
        S_TAIL: begin
          if (in_rx_byte != crcfr_pkg::tail_byte(tail_idx_r)) begin
            push             = 1'b1;
            push_desc.status = crcfr_pkg::ST_TAIL;
            state_nxt        = S_HUNT;
          end else if (tail_idx_r != crcfr_pkg::TAIL_LAST) begin
            tail_idx_nxt = tail_idx_r + 1'b1;
          end else begin
            push      = 1'b1;
            state_nxt = S_HUNT;
            if (rx_crc_r != crc_r) begin
              push_desc.status = crcfr_pkg::ST_CRC;
            end else begin
              push_desc.n = pay_n_r;
              // A good frame with payload hands its bank over to the emitter.
              if (pay_n_r != '0) begin
                set_mask         = 2'b01 << bank_r;
                bank_nxt         = ~bank_r;
              end
            end
          end
        end
        default: begin
          state_nxt = S_HUNT;
        end
      endcase
    end

    clr_mask = clr.valid ? (2'b01 << clr.bank) : 2'b00;
    busy_nxt = (busy_r & ~clr_mask) | set_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_HUNT;
      max_len_r <= crcfr_pkg::MAX_BODY_RST;
      bank_r    <= 1'b0;
      busy_r    <= 2'b00;
    end else begin
      state_r   <= state_nxt;
      max_len_r <= max_len_nxt;
      bank_r    <= bank_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_hi_r   <= len_hi_nxt;
    pay_n_r    <= pay_n_nxt;
    pay_cnt_r  <= pay_cnt_nxt;
    crc_r      <= crc_nxt;
    rx_crc_r   <= rx_crc_nxt;
    cmd_r      <= cmd_nxt;
    tail_idx_r <= tail_idx_nxt;
  end

  // Payload must never be written into a bank that still waits to be read out.
  `CRCFR_ASSERT(a_no_busy_write, !(ram_wr_en && busy_r[bank_r]))
  // Handing over a bank marks it busy and moves to the other bank.
  `CRCFR_ASSERT_NEXT(a_bank_handover, |set_mask, !$stable(bank_r) && busy_r[$past(bank_r)])

endmodule

FILE: src/crcfr_back.sv
// Item emitter: walks queued frame descriptors, reads payload bytes from the RAM
// and drives the result channel through a read stage and an output register.
// Uses crcfr_pkg.
`timescale 1ns / 1ps
`include "crc16_checked_frame_receiver_unit_defines.svh"

module crcfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crcfr_pkg::desc_t     head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 ram_rd_en,
  output crcfr_pkg::addr_t     ram_rd_addr,
  input  logic [7:0]           ram_rd_data,
  output crcfr_pkg::clr_t      clr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_command,
  output logic [7:0]           out_payload_byte,
  output logic [4:0]           out_byte_index,
  output logic                 out_has_payload,
  output logic [1:0]           out_frame_status,
  output logic                 out_last
);

  crcfr_pkg::idx_t    idx_r, idx_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic [15:0]        s1_cmd_r;
  crcfr_pkg::idx_t    s1_idx_r;
  logic               s1_has_r;
  crcfr_pkg::status_t s1_status_r;
  logic               s1_last_r;

  logic               o_valid_r, o_valid_nxt;
  logic [15:0]        o_cmd_r;
  logic [7:0]         o_byte_r;
  crcfr_pkg::bidx_t   o_idx_r;
  logic               o_has_r;
  crcfr_pkg::status_t o_status_r;
  logic               o_last_r;

  logic               o_free;
  logic               advance;
  logic               issue;
  logic               has;
  logic               item_last;

  assign o_free    = !o_valid_r || !out_stall;
  assign advance   = s1_valid_r && o_free;
  assign issue     = !q_empty && (!s1_valid_r || advance);
  assign has       = (head.n != '0);
  assign item_last = !has || ((crcfr_pkg::cnt_t'(idx_r) + 1'b1) == head.n);

  assign pop         = issue && item_last;
  assign ram_rd_en   = issue && has;
  assign ram_rd_addr = {head.bank, idx_r};
  assign clr         = '{valid: pop && has, bank: head.bank};

  always_comb begin
    idx_nxt = idx_r;
    if (issue) begin
      idx_nxt = item_last ? '0 : idx_r + 1'b1;
    end
    s1_valid_nxt = issue || (s1_valid_r && !advance);
    o_valid_nxt  = o_free ? s1_valid_r : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_cmd_r    <= head.cmd;
      s1_idx_r    <= idx_r;
      s1_has_r    <= has;
      s1_status_r <= head.status;
      s1_last_r   <= item_last;
    end
    // The RAM read data is held while the read stage waits, as no new read is issued.
    if (advance) begin
      o_cmd_r    <= s1_cmd_r;
      o_byte_r   <= s1_has_r ? ram_rd_data : 8'h00;
      o_idx_r    <= s1_has_r ? crcfr_pkg::bidx_t'(s1_idx_r) : '0;
      o_has_r    <= s1_has_r;
      o_status_r <= s1_status_r;
      o_last_r   <= s1_last_r;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_command      = o_cmd_r;
  assign out_payload_byte = o_byte_r;
  assign out_byte_index   = o_idx_r;
  assign out_has_payload  = o_has_r;
  assign out_frame_status = o_status_r;
  assign out_last         = o_last_r;

  // Every item but the final one of a frame carries a payload byte.
  `CRCFR_ASSERT(a_nonlast_has_payload, !(o_valid_r && !o_last_r && !o_has_r))
  // Items without payload are always the only item of their frame.
  `CRCFR_ASSERT(a_empty_is_last, !(s1_valid_r && !s1_has_r && !s1_last_r))

endmodule

FILE: src/crc16_checked_frame_receiver_unit.sv
// Top level of the CRC-16/MODBUS checked serial frame receiver.
// Instantiates crcfr_front, crcfr_queue, crcfr_ram and crcfr_back; uses crcfr_pkg.
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+------------------------------------------
//   in_      | input     | in_valid/in_stall  | in_rx_byte
//   out_     | output    | out_valid/out_stall| out_command, out_payload_byte,
//            |           |                    | out_byte_index, out_has_payload,
//            |           |                    | out_frame_status, out_last
//   cfg_     | input     | cfg_wr_en          | cfg_wr_data (max_body_len)
//
// The parser takes one byte per cycle while not stalled; one state step per byte, and one
// CRC table step per command or payload byte. A frame's result items leave at one per cycle
// while out_stall is low, after the descriptor queue, the payload RAM read and the output register.
// The parser stalls when the two-entry descriptor queue is full, or when it would write
// payload into a RAM bank whose previous frame has not yet been read out.
// Reset is synchronous and active low; there is no clearing pass.
`timescale 1ns / 1ps

module crc16_checked_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_command,
  output logic [7:0]  out_payload_byte,
  output logic [4:0]  out_byte_index,
  output logic        out_has_payload,
  output logic [1:0]  out_frame_status,
  output logic        out_last
);

  logic               push;
  crcfr_pkg::desc_t   push_desc;
  logic               pop;
  crcfr_pkg::desc_t   head;
  logic               q_empty;
  logic               q_full;
  logic               ram_wr_en;
  crcfr_pkg::addr_t   ram_wr_addr;
  logic [7:0]         ram_wr_data;
  logic               ram_rd_en;
  crcfr_pkg::addr_t   ram_rd_addr;
  logic [7:0]         ram_rd_data;
  crcfr_pkg::clr_t    clr;

  crcfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .q_full      (q_full),
    .push        (push),
    .push_desc   (push_desc),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .clr         (clr)
  );

  crcfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  crcfr_ram #(
    .WIDTH (8),
    .DEPTH (crcfr_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  crcfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .ram_rd_en        (ram_rd_en),
    .ram_rd_addr      (ram_rd_addr),
    .ram_rd_data      (ram_rd_data),
    .clr              (clr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_has_payload  (out_has_payload),
    .out_frame_status (out_frame_status),
    .out_last         (out_last)
  );

endmodule

FILE: dv/crc16_checked_frame_receiver_unit_test.sv
// Self-checking testbench for crc16_checked_frame_receiver_unit: builds serial frames,
// predicts every result transaction in place and checks them against the block.
// Depends on crcfr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module crc16_checked_frame_receiver_unit_test;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES     = 200;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PRESSURE_FRAMES = 3;
  localparam int PRESSURE_LEN    = 4;
  localparam int NO_TAIL_FLAW    = -1;
  localparam logic [31:0] TAIL_WORD = 32'hFFFD_FEFF;

  typedef enum logic [8:0] {
    P_HUNT   = 9'b000000001,
    P_LEN_HI = 9'b000000010,
    P_LEN_LO = 9'b000000100,
    P_CMD_HI = 9'b000001000,
    P_CMD_LO = 9'b000010000,
    P_BODY   = 9'b000100000,
    P_CRC_HI = 9'b001000000,
    P_CRC_LO = 9'b010000000,
    P_TAIL   = 9'b100000000
  } rx_phase_t;

  typedef struct packed {
    logic [15:0]        cmd;
    logic [7:0]         data;
    logic [4:0]         idx;
    logic               has;
    crcfr_pkg::status_t status;
    logic               last;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = 6'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_command;
  logic [7:0]  out_payload_byte;
  logic [4:0]  out_byte_index;
  logic        out_has_payload;
  logic [1:0]  out_frame_status;
  logic        out_last;

  crc16_checked_frame_receiver_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_has_payload  (out_has_payload),
    .out_frame_status (out_frame_status),
    .out_last         (out_last)
  );

  always #2 clk = ~clk;

  // Predictor state, a shadow of the receiver.
  rx_phase_t   rx_phase = P_HUNT;
  logic [1:0]  tail_pos;
  logic [15:0] body_len = 16'h0000;
  logic [15:0] body_cnt = 16'h0000;
  logic [15:0] crc_run = crcfr_pkg::CRC_INIT;
  logic [15:0] crc_got = 16'h0000;
  logic [15:0] cmd_word = 16'h0000;
  logic [7:0]  body_store [0:crcfr_pkg::MAX_PAYLOAD-1];
  logic [5:0]  body_limit = crcfr_pkg::MAX_BODY_RST;

  rx_item_t    rx_items_due [$];
  logic [7:0]  tx_q [$];
  logic [7:0]  pay_src [0:crcfr_pkg::MAX_PAYLOAD-1];

  int unsigned mismatches = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  bit          stall_on = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          run_left = 0;
  bit          run_stall = 1'b0;
  int          idle_cycles = 0;

  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    int k;
    r = c ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ crcfr_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] tail_expect(input int k);
    return TAIL_WORD[31 - 8 * k -: 8];
  endfunction

  function automatic void add_item(input logic [15:0] cmd, input logic [7:0] data,
                                   input logic [4:0] idx, input logic has,
                                   input crcfr_pkg::status_t status, input logic last);
    rx_items_due.push_back('{cmd, data, idx, has, status, last});
  endfunction

  // Advances the shadow parser by one accepted byte and queues what it emits.
  function automatic void frame_parse_byte(input logic [7:0] b);
    int n;
    int i;
    case (rx_phase)
      P_HUNT: begin
        if (b == crcfr_pkg::HEADER_BYTE) rx_phase = P_LEN_HI;
      end
      P_LEN_HI: begin
        body_len = {b, 8'h00};
        rx_phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        body_len[7:0] = b;
        if (body_len < 2 || body_len > body_limit ||
            body_len > crcfr_pkg::MAX_PAYLOAD + 2) begin
          add_item(16'h0000, 8'h00, 5'd0, 1'b0, crcfr_pkg::ST_LEN, 1'b1);
          rx_phase = P_HUNT;
        end else begin
          crc_run = crcfr_pkg::CRC_INIT;
          body_cnt = 16'h0000;
          rx_phase = P_CMD_HI;
        end
      end
      P_CMD_HI: begin
        cmd_word = {b, 8'h00};
        crc_run = modbus_crc_byte(crc_run, b);
        body_cnt = 16'd1;
        rx_phase = P_CMD_LO;
      end
      P_CMD_LO: begin
        cmd_word[7:0] = b;
        crc_run = modbus_crc_byte(crc_run, b);
        body_cnt = 16'd2;
        rx_phase = (body_len > 2) ? P_BODY : P_CRC_HI;
      end
      P_BODY: begin
        body_store[body_cnt - 2] = b;
        crc_run = modbus_crc_byte(crc_run, b);
        body_cnt = body_cnt + 16'd1;
        if (body_cnt >= body_len) rx_phase = P_CRC_HI;
      end
      P_CRC_HI: begin
        crc_got = {b, 8'h00};
        rx_phase = P_CRC_LO;
      end
      P_CRC_LO: begin
        crc_got[7:0] = b;
        tail_pos = 2'd0;
        rx_phase = P_TAIL;
      end
      P_TAIL: begin
        if (b != tail_expect(tail_pos)) begin
          add_item(cmd_word, 8'h00, 5'd0, 1'b0, crcfr_pkg::ST_TAIL, 1'b1);
          rx_phase = P_HUNT;
        end else if (tail_pos != crcfr_pkg::TAIL_LAST) begin
          tail_pos = tail_pos + 2'd1;
        end else begin
          rx_phase = P_HUNT;
          n = body_len - 2;
          // The CRC is judged only once the whole tail has matched.
          if (crc_got != crc_run) begin
            add_item(cmd_word, 8'h00, 5'd0, 1'b0, crcfr_pkg::ST_CRC, 1'b1);
          end else if (n == 0) begin
            add_item(cmd_word, 8'h00, 5'd0, 1'b0, crcfr_pkg::ST_OK, 1'b1);
          end else begin
            for (i = 0; i < n; i++) begin
              add_item(cmd_word, body_store[i], 5'(i), 1'b1, crcfr_pkg::ST_OK, i == n - 1);
            end
          end
        end
      end
      default: rx_phase = P_HUNT;
    endcase
  endfunction

  function automatic void fill_payload_random();
    int k;
    for (k = 0; k < crcfr_pkg::MAX_PAYLOAD; k++) pay_src[k] = 8'($urandom);
  endfunction

  // Queues one frame built from pay_src; a nonzero crc_mask corrupts the CRC.
  function automatic void queue_frame(input logic [15:0] cmd, input int n,
                                      input logic [15:0] crc_mask, input int bad_tail_at,
                                      input logic [7:0] bad_val);
    logic [15:0] len;
    logic [15:0] crc;
    int k;
    len = 16'(n + 2);
    crc = modbus_crc_byte(modbus_crc_byte(crcfr_pkg::CRC_INIT, cmd[15:8]), cmd[7:0]);
    tx_q.push_back(crcfr_pkg::HEADER_BYTE);
    tx_q.push_back(len[15:8]);
    tx_q.push_back(len[7:0]);
    tx_q.push_back(cmd[15:8]);
    tx_q.push_back(cmd[7:0]);
    for (k = 0; k < n; k++) begin
      tx_q.push_back(pay_src[k]);
      crc = modbus_crc_byte(crc, pay_src[k]);
    end
    crc = crc ^ crc_mask;
    tx_q.push_back(crc[15:8]);
    tx_q.push_back(crc[7:0]);
    for (k = 0; k < 4; k++) tx_q.push_back((k == bad_tail_at) ? bad_val : tail_expect(k));
  endfunction

  function automatic void queue_bad_len(input logic [15:0] len);
    tx_q.push_back(crcfr_pkg::HEADER_BYTE);
    tx_q.push_back(len[15:8]);
    tx_q.push_back(len[7:0]);
  endfunction

  // Offers one byte and returns at the edge where the transaction completes.
  task automatic send_byte(input logic [7:0] b);
    logic taken;
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    frame_parse_byte(b);
  endtask

  task automatic send_queued();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  // Brings the parser back to hunting and waits until the block has gone quiet.
  task automatic quiesce();
    while (rx_phase != P_HUNT) send_byte(8'h00);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rx_items_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [5:0] limit);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    body_limit = limit;
  endtask

  task automatic test_good_frames();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    fill_payload_random();
    pay_src[0] = 8'h00;
    pay_src[1] = 8'hFF;
    pay_src[2] = crcfr_pkg::HEADER_BYTE;
    // Largest body at the reset limit reaches the top byte index; header bytes are data.
    queue_frame({crcfr_pkg::HEADER_BYTE, crcfr_pkg::HEADER_BYTE}, crcfr_pkg::MAX_PAYLOAD,
                16'h0000, NO_TAIL_FLAW, 8'h00);
    send_queued();
    quiesce();
  endtask

  task automatic test_bad_length();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    queue_bad_len(16'h0001);
    queue_bad_len(16'(crcfr_pkg::MAX_LEN + 1));
    queue_bad_len(16'hFFFF);
    send_queued();
    quiesce();
  endtask

  task automatic test_tail_and_crc();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    pay_src[0] = 8'h3C;
    // A header byte in place of the first tail byte is not taken as a new header.
    queue_frame(16'h1234, 1, 16'h0000, 0, crcfr_pkg::HEADER_BYTE);
    queue_frame(16'h7FFE, 0, 16'h8000, NO_TAIL_FLAW, 8'h00);
    // Bad tail wins over a bad CRC.
    queue_frame(16'h8001, 0, 16'h0001, 3, 8'h00);
    send_queued();
    quiesce();
  endtask

  task automatic test_limit_extremes();
    gaps_on = 1'b0;
    stall_on = 1'b1;
    reconfigure(6'd63);
    queue_bad_len(16'(crcfr_pkg::MAX_LEN + 1));
    send_queued();
    reconfigure(6'd0);
    queue_bad_len(16'd2);
    send_queued();
    reconfigure(6'd1);
    queue_bad_len(16'd2);
    send_queued();
    reconfigure(6'd2);
    queue_frame(16'h0303, 0, 16'h0000, NO_TAIL_FLAW, 8'h00);
    queue_bad_len(16'd3);
    send_queued();
    reconfigure(crcfr_pkg::MAX_BODY_RST);
  endtask

  task automatic test_backpressure();
    int k;
    gaps_on = 1'b0;
    stall_on = 1'b1;
    hold_req = 1'b1;
    for (k = 0; k < PRESSURE_FRAMES; k++) begin
      fill_payload_random();
      queue_frame(16'($urandom), PRESSURE_LEN, 16'h0000, NO_TAIL_FLAW, 8'h00);
    end
    send_queued();
    gaps_on = 1'b1;
    quiesce();
  endtask

  // Receiver stall pattern: random runs, plus a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_stall = ($urandom_range(0, 2) == 0);
        run_left = run_stall ? $urandom_range(1, 4) : $urandom_range(1, 10);
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  function automatic void report_item(input string what, input rx_item_t e, input rx_item_t g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected cmd=%h byte=%h idx=%0d has=%b status=%0d last=%b", what,
               e.cmd, e.data, e.idx, e.has, e.status, e.last);
      $display("  got cmd=%h byte=%h idx=%0d has=%b status=%0d last=%b",
               g.cmd, g.data, g.idx, g.has, g.status, g.last);
    end
  endfunction

  // Outputs are sampled mid-cycle; a transaction seen here completes at the next edge.
  always @(negedge clk) begin
    rx_item_t got;
    rx_item_t exp;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_command, out_payload_byte, out_byte_index, out_has_payload,
              out_frame_status, out_last};
      if (rx_items_due.size() == 0) begin
        report_item("result with nothing expected", '0, got);
      end else begin
        exp = rx_items_due.pop_front();
        if (got !== exp) report_item("result mismatch", exp, got);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_frames();
    test_bad_length();
    test_tail_and_crc();
    test_limit_extremes();
    test_backpressure();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && rx_items_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
